### sv/htw_pkg.sv
// Shared constants and types for the hashed timing wheel.
// No dependencies; imported by every module of the block.
`default_nettype none
package htw_pkg;

	// Default sizes of the wheel and the entry pool.
	localparam int SLOTS_DEF      = 100;
	localparam int TICK_MS_DEF    = 10;
	localparam int POOL_DEPTH_DEF = 64;

	// Maximum number of expiries reported by one tick.
	localparam int MAX_RESULTS = 64;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// Fixed field widths.
	localparam int HANDLE_W = 8;
	localparam int DELAY_W  = 16;
	localparam int TIME_W   = 40;
	localparam int KIND_W   = 2;

	// Reciprocal scaling of the shared divider. The quotient is exact for every
	// DELAY_W-bit dividend as long as the divisor is at most 2**10, which covers
	// the tick length and the slot count.
	localparam int RECIP_SHIFT = DELAY_W + 10;
	localparam int RECIP_W     = RECIP_SHIFT + 1;

	// Operation and result codes.
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [KIND_W-1:0] KIND_ADDED   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

	// Write enables of the storage module.
	typedef struct packed {
		logic heads;
		logic links;
		logic entry;
	} htw_we_t;

endpackage
`default_nettype wire

### sv/htw_div.sv
// Divider for small constant divisors: one shared multiplier, used once with the
// reciprocal for the quotient and once with the divisor for the remainder.
// Depends on htw_pkg for the operand widths and the reciprocal scaling.
`default_nettype none
module htw_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [htw_pkg::DELAY_W-1:0] dividend,
	input  wire logic [htw_pkg::DELAY_W-1:0] divisor,
	input  wire logic [htw_pkg::RECIP_W-1:0] recip,
	output logic                             done,
	output logic [htw_pkg::DELAY_W-1:0]      quot,
	output logic [htw_pkg::DELAY_W-1:0]      rem
);
	import htw_pkg::*;

	localparam int PROD_W = RECIP_SHIFT + DELAY_W;

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_QUOT = 3'b010,
		D_REM  = 3'b100
	} div_state_t;

	div_state_t          st_q;
	logic                done_q;
	logic [DELAY_W-1:0]  num_q;
	logic [DELAY_W-1:0]  div_q;
	logic [RECIP_W-1:0]  recip_q;
	logic [DELAY_W-1:0]  quot_q;
	logic [DELAY_W-1:0]  rem_q;
	logic [DELAY_W-1:0]  mul_a;
	logic [RECIP_W-1:0]  mul_b;
	logic [PROD_W-1:0]   product;

	// Shared multiplier: dividend times reciprocal, then quotient times divisor.
	assign mul_a   = (st_q == D_REM) ? quot_q : num_q;
	assign mul_b   = (st_q == D_REM) ? RECIP_W'(div_q) : recip_q;
	assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Sequencing of the two passes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				st_q <= D_QUOT;
			end else begin
				unique case (st_q)
					D_QUOT: begin
						st_q <= D_REM;
					end
					D_REM: begin
						st_q   <= D_IDLE;
						done_q <= 1'b1;
					end
					default: begin
						st_q <= D_IDLE;
					end
				endcase
			end
		end
	end

	// Operands, quotient and remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q   <= dividend;
			div_q   <= divisor;
			recip_q <= recip;
		end else if (st_q == D_QUOT) begin
			quot_q <= product[PROD_W-1:RECIP_SHIFT];
		end else if (st_q == D_REM) begin
			rem_q <= num_q - product[DELAY_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

### sv/htw_store.sv
// Bucket head, link and entry memories of the timing wheel, read registered.
// Depends on htw_pkg for field widths and the write enable struct.
`default_nettype none
module htw_store #(
	parameter int SLOTS      = htw_pkg::SLOTS_DEF,
	parameter int POOL_DEPTH = htw_pkg::POOL_DEPTH_DEF,
	parameter int SLOT_W     = $clog2(SLOTS),
	parameter int IDX_W      = $clog2(POOL_DEPTH),
	parameter int PTR_W      = $clog2(POOL_DEPTH + 1)
) (
	input  wire logic                         clk,
	input  wire htw_pkg::htw_we_t             we,
	input  wire logic [SLOT_W-1:0]            heads_waddr,
	input  wire logic [PTR_W-1:0]             heads_wdata,
	input  wire logic [SLOT_W-1:0]            heads_raddr,
	output logic [PTR_W-1:0]                  heads_rdata,
	input  wire logic [IDX_W-1:0]             links_waddr,
	input  wire logic [PTR_W-1:0]             links_wdata,
	input  wire logic [IDX_W-1:0]             entry_waddr,
	input  wire logic [htw_pkg::HANDLE_W-1:0] entry_whandle,
	input  wire logic [htw_pkg::TIME_W-1:0]   entry_wdeadline,
	input  wire logic [IDX_W-1:0]             pool_raddr,
	output logic [PTR_W-1:0]                  links_rdata,
	output logic [htw_pkg::HANDLE_W-1:0]      entry_rhandle,
	output logic [htw_pkg::TIME_W-1:0]        entry_rdeadline
);
	import htw_pkg::*;

	logic [PTR_W-1:0]    heads_mem [SLOTS];
	logic [PTR_W-1:0]    links_mem [POOL_DEPTH];
	logic [HANDLE_W-1:0] handle_mem [POOL_DEPTH];
	logic [TIME_W-1:0]   deadline_mem [POOL_DEPTH];

	// Bucket heads.
	always_ff @(posedge clk) begin
		if (we.heads) begin
			heads_mem[heads_waddr] <= heads_wdata;
		end
		heads_rdata <= heads_mem[heads_raddr];
	end

	// Entry links, shared by the free list and the bucket lists.
	always_ff @(posedge clk) begin
		if (we.links) begin
			links_mem[links_waddr] <= links_wdata;
		end
		links_rdata <= links_mem[pool_raddr];
	end

	// Entry handles and deadlines.
	always_ff @(posedge clk) begin
		if (we.entry) begin
			handle_mem[entry_waddr]   <= entry_whandle;
			deadline_mem[entry_waddr] <= entry_wdeadline;
		end
		entry_rhandle   <= handle_mem[pool_raddr];
		entry_rdeadline <= deadline_mem[pool_raddr];
	end

endmodule
`default_nettype wire

### sv/hashed_timing_wheel_top.sv
// Hashed timing wheel: SLOTS buckets, a pool of POOL_DEPTH entries. After reset the block sweeps
// its memories before taking a transfer. An add keeps the block busy for two passes of the shared
// reciprocal divider (delay / TICK_MS, then modulo SLOTS) and one read and one write of the
// memories; a full pool answers without the divider. A tick walks the visited bucket through
// the single read port of the link memory and can be held by any output stall. One item is
// worked on at a time; in_stall is low only while idle. TICK_MS and SLOTS must not exceed 1024.
// Depends on htw_pkg, htw_div and htw_store.
`default_nettype none
module hashed_timing_wheel_top #(
	parameter int SLOTS      = htw_pkg::SLOTS_DEF,
	parameter int TICK_MS    = htw_pkg::TICK_MS_DEF,
	parameter int POOL_DEPTH = htw_pkg::POOL_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         op,
	input  wire logic [htw_pkg::HANDLE_W-1:0] timer_handle,
	input  wire logic [htw_pkg::DELAY_W-1:0]  delay_ms,
	input  wire logic [htw_pkg::TIME_W-1:0]   now_ms,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [htw_pkg::KIND_W-1:0]        kind,
	output logic [htw_pkg::HANDLE_W-1:0]      expired_handle,
	output logic                              last
);
	import htw_pkg::*;

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int IDX_W  = $clog2(POOL_DEPTH);
	localparam int PTR_W  = $clog2(POOL_DEPTH + 1);
	localparam int STP_W  = $clog2(POOL_DEPTH + 1);
	localparam int INIT_N = (SLOTS > POOL_DEPTH) ? SLOTS : POOL_DEPTH;
	localparam int INIT_W = $clog2(INIT_N);
	localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_DEPTH);

	// Rounded-up reciprocals of the two constant divisors.
	localparam logic [RECIP_W-1:0] RECIP_TICK  =
		RECIP_W'(((1 << RECIP_SHIFT) + TICK_MS - 1) / TICK_MS);
	localparam logic [RECIP_W-1:0] RECIP_SLOTS =
		RECIP_W'(((1 << RECIP_SHIFT) + SLOTS - 1) / SLOTS);

	typedef enum logic [11:0] {
		S_INIT  = 12'b0000_0000_0001,
		S_IDLE  = 12'b0000_0000_0010,
		S_ADIV1 = 12'b0000_0000_0100,
		S_ADIV2 = 12'b0000_0000_1000,
		S_ARD   = 12'b0000_0001_0000,
		S_AWR   = 12'b0000_0010_0000,
		S_THEAD = 12'b0000_0100_0000,
		S_TCHK  = 12'b0000_1000_0000,
		S_TEVAL = 12'b0001_0000_0000,
		S_TFREE = 12'b0010_0000_0000,
		S_TEND  = 12'b0100_0000_0000,
		S_EMIT  = 12'b1000_0000_0000
	} state_t;

	state_t              st_q;
	state_t              ret_q;
	logic [INIT_W-1:0]   init_q;
	logic [PTR_W-1:0]    free_q;
	logic [SLOT_W-1:0]   pos_q;
	logic [SLOT_W-1:0]   pos_nx;
	logic [SLOT_W-1:0]   slot_q;
	logic [PTR_W-1:0]    cur_q;
	logic [PTR_W-1:0]    prev_q;
	logic [PTR_W-1:0]    next_q;
	logic [STP_W-1:0]    steps_q;
	logic [CNT_W-1:0]    count_q;
	logic                have_q;
	logic [HANDLE_W-1:0] held_q;
	logic [HANDLE_W-1:0] hnd_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [DELAY_W-1:0]  delay_q;
	logic [TIME_W-1:0]   now_q;
	logic [KIND_W-1:0]   pend_kind_q;
	logic [HANDLE_W-1:0] pend_handle_q;
	logic                pend_last_q;
	logic                out_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [HANDLE_W-1:0] handle_out_q;
	logic                last_q;

	logic                in_xfer;
	logic                can_emit;
	logic                div_start;
	logic [DELAY_W-1:0]  div_dividend;
	logic [DELAY_W-1:0]  div_divisor;
	logic [RECIP_W-1:0]  div_recip;
	logic                div_done;
	logic [DELAY_W-1:0]  div_quot;
	logic [DELAY_W-1:0]  div_rem;
	logic [DELAY_W-1:0]  ahead;
	logic [SLOT_W:0]     slot_sum;
	logic                due;

	htw_we_t             we;
	logic [SLOT_W-1:0]   heads_waddr;
	logic [PTR_W-1:0]    heads_wdata;
	logic [SLOT_W-1:0]   heads_raddr;
	logic [PTR_W-1:0]    heads_rdata;
	logic [IDX_W-1:0]    links_waddr;
	logic [PTR_W-1:0]    links_wdata;
	logic [IDX_W-1:0]    pool_raddr;
	logic [PTR_W-1:0]    links_rdata;
	logic [HANDLE_W-1:0] entry_rhandle;
	logic [TIME_W-1:0]   entry_rdeadline;

	assign in_stall = (st_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign can_emit = !out_valid_q || !out_stall;

	assign pos_nx   = (pos_q == SLOT_W'(SLOTS - 1)) ? '0 : pos_q + SLOT_W'(1);
	assign ahead    = (div_quot == '0) ? DELAY_W'(1) : div_quot;
	assign slot_sum = (SLOT_W + 1)'(pos_q) + (SLOT_W + 1)'(div_rem);
	assign due      = entry_rdeadline <= now_q;

	// Shared divider: delay over tick length, then wheel offset modulo the slot count.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = delay_ms;
		div_divisor  = DELAY_W'(TICK_MS);
		div_recip    = RECIP_TICK;
		if (st_q == S_IDLE && in_xfer && op == OP_ADD && free_q != NIL) begin
			div_start = 1'b1;
		end else if (st_q == S_ADIV1 && div_done) begin
			div_start    = 1'b1;
			div_dividend = ahead;
			div_divisor  = DELAY_W'(SLOTS);
			div_recip    = RECIP_SLOTS;
		end
	end

	htw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.recip    (div_recip),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Memory addresses and writes for each sequencer step.
	always_comb begin
		we          = '0;
		heads_waddr = pos_q;
		heads_wdata = links_rdata;
		heads_raddr = (st_q == S_IDLE) ? pos_nx : slot_q;
		links_waddr = cur_q[IDX_W-1:0];
		links_wdata = free_q;
		pool_raddr  = (st_q == S_ARD) ? free_q[IDX_W-1:0] : cur_q[IDX_W-1:0];
		unique case (st_q)
			S_INIT: begin
				we.heads    = {1'b0, init_q} < (INIT_W + 1)'(SLOTS);
				heads_waddr = init_q[SLOT_W-1:0];
				heads_wdata = NIL;
				we.links    = {1'b0, init_q} < (INIT_W + 1)'(POOL_DEPTH);
				links_waddr = init_q[IDX_W-1:0];
				links_wdata = PTR_W'(init_q) + PTR_W'(1);
			end
			S_AWR: begin
				we.heads    = 1'b1;
				heads_waddr = slot_q;
				heads_wdata = free_q;
				we.links    = 1'b1;
				links_waddr = free_q[IDX_W-1:0];
				links_wdata = heads_rdata;
				we.entry    = 1'b1;
			end
			S_TEVAL: begin
				if (due) begin
					if (prev_q != NIL) begin
						we.links    = 1'b1;
						links_waddr = prev_q[IDX_W-1:0];
						links_wdata = links_rdata;
					end else begin
						we.heads = 1'b1;
					end
				end
			end
			S_TFREE: begin
				we.links = 1'b1;
			end
			default: begin
			end
		endcase
	end

	htw_store #(
		.SLOTS      (SLOTS),
		.POOL_DEPTH (POOL_DEPTH),
		.SLOT_W     (SLOT_W),
		.IDX_W      (IDX_W),
		.PTR_W      (PTR_W)
	) u_store (
		.clk             (clk),
		.we              (we),
		.heads_waddr     (heads_waddr),
		.heads_wdata     (heads_wdata),
		.heads_raddr     (heads_raddr),
		.heads_rdata     (heads_rdata),
		.links_waddr     (links_waddr),
		.links_wdata     (links_wdata),
		.entry_waddr     (free_q[IDX_W-1:0]),
		.entry_whandle   (handle_q),
		.entry_wdeadline (now_q + TIME_W'(delay_q)),
		.pool_raddr      (pool_raddr),
		.links_rdata     (links_rdata),
		.entry_rhandle   (entry_rhandle),
		.entry_rdeadline (entry_rdeadline)
	);

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_INIT;
			ret_q   <= S_IDLE;
			init_q  <= '0;
			free_q  <= '0;
			pos_q   <= '0;
			steps_q <= '0;
			count_q <= '0;
			have_q  <= 1'b0;
		end else begin
			unique case (st_q)
				S_INIT: begin
					init_q <= init_q + INIT_W'(1);
					if (init_q == INIT_W'(INIT_N - 1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						if (op == OP_TICK) begin
							pos_q   <= pos_nx;
							steps_q <= '0;
							count_q <= '0;
							have_q  <= 1'b0;
							st_q    <= S_THEAD;
						end else if (free_q == NIL) begin
							ret_q <= S_IDLE;
							st_q  <= S_EMIT;
						end else begin
							st_q <= S_ADIV1;
						end
					end
				end
				S_ADIV1: begin
					if (div_done) begin
						st_q <= S_ADIV2;
					end
				end
				S_ADIV2: begin
					if (div_done) begin
						st_q <= S_ARD;
					end
				end
				S_ARD: begin
					st_q <= S_AWR;
				end
				S_AWR: begin
					free_q <= links_rdata;
					ret_q  <= S_IDLE;
					st_q   <= S_EMIT;
				end
				S_THEAD: begin
					st_q <= S_TCHK;
				end
				S_TCHK: begin
					if (cur_q == NIL || steps_q == STP_W'(POOL_DEPTH) ||
						count_q == CNT_W'(MAX_RESULTS)) begin
						st_q <= S_TEND;
					end else begin
						st_q <= S_TEVAL;
					end
				end
				S_TEVAL: begin
					steps_q <= steps_q + STP_W'(1);
					st_q    <= due ? S_TFREE : S_TCHK;
				end
				S_TFREE: begin
					free_q  <= cur_q;
					count_q <= count_q + CNT_W'(1);
					have_q  <= 1'b1;
					if (have_q) begin
						ret_q <= S_TCHK;
						st_q  <= S_EMIT;
					end else begin
						st_q <= S_TCHK;
					end
				end
				S_TEND: begin
					if (have_q) begin
						ret_q <= S_IDLE;
						st_q  <= S_EMIT;
					end else begin
						st_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (can_emit) begin
						st_q <= ret_q;
					end
				end
				default: begin
					st_q <= S_INIT;
				end
			endcase
		end
	end

	// Working registers of the current item.
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				handle_q      <= timer_handle;
				delay_q       <= delay_ms;
				now_q         <= now_ms;
				prev_q        <= NIL;
				pend_kind_q   <= KIND_FULL;
				pend_handle_q <= '0;
				pend_last_q   <= 1'b1;
			end
			S_ADIV2: begin
				slot_q <= (slot_sum >= (SLOT_W + 1)'(SLOTS)) ?
					SLOT_W'(slot_sum - (SLOT_W + 1)'(SLOTS)) : slot_sum[SLOT_W-1:0];
			end
			S_AWR: begin
				pend_kind_q   <= KIND_ADDED;
				pend_handle_q <= '0;
				pend_last_q   <= 1'b1;
			end
			S_THEAD: begin
				cur_q <= heads_rdata;
			end
			S_TEVAL: begin
				next_q <= links_rdata;
				hnd_q  <= entry_rhandle;
				if (!due) begin
					prev_q <= cur_q;
					cur_q  <= links_rdata;
				end
			end
			S_TFREE: begin
				cur_q         <= next_q;
				held_q        <= hnd_q;
				pend_kind_q   <= KIND_EXPIRED;
				pend_handle_q <= held_q;
				pend_last_q   <= 1'b0;
			end
			S_TEND: begin
				pend_kind_q   <= KIND_EXPIRED;
				pend_handle_q <= held_q;
				pend_last_q   <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Output register; a result waits here until the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == S_EMIT && can_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_EMIT && can_emit) begin
			kind_q       <= pend_kind_q;
			handle_out_q <= pend_handle_q;
			last_q       <= pend_last_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign expired_handle = handle_out_q;
	assign last           = last_q;

	// Checks on the sequencer.
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= NIL) else $error("free list head out of range");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= SLOT_W'(SLOTS - 1)) else $error("wheel position out of range");

	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && op == OP_TICK) |=> st_q == S_THEAD)
		else $error("tick transfer did not start the bucket walk");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == S_ADIV1 || st_q == S_ADIV2))
		else $error("divider finished outside an add");

	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= STP_W'(POOL_DEPTH)) else $error("walk exceeded pool depth");

endmodule
`default_nettype wire
